// File: sv/cftp_pkg.sv
// shared types and defaults for the can frame text parser
package cftp_pkg;

  localparam int unsigned MaxDataBytesDefault = 8;

  // one character, already decoded
  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
    logic       is_dot;
    logic       is_hash;
    logic       is_remote;
    logic       is_nul;
    logic       dlc_ok;
  } char_info_t;

  // one finished frame
  typedef struct packed {
    logic        frame_ok;
    logic [11:0] msg_id;
    logic        remote_request;
    logic [3:0]  data_length;
    logic [63:0] payload;
  } frame_res_t;

endpackage

// File: sv/cftp_char_decode.sv
// character classifier: hex value and the marker characters of the frame syntax
module cftp_char_decode
  import cftp_pkg::*;
(
  input  logic [7:0] ch_i,
  output char_info_t info_o
);

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpR   = 8'h52;
  localparam logic [7:0] ChLowR  = 8'h72;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [3:0] DlcMax  = 4'd8;
  localparam logic [3:0] LetterOffset = 4'd9;

  logic is_digit;
  logic is_letter;

  always_comb begin
    is_digit  = ch_i inside {[ChZero:ChNine]};
    is_letter = (ch_i inside {[ChUpA:ChUpF]}) || (ch_i inside {[ChLowA:ChLowF]});

    info_o.is_hex    = is_digit || is_letter;
    // 'A'..'F' and 'a'..'f' both have low nibble 1..6
    info_o.nibble    = is_digit ? ch_i[3:0] : ch_i[3:0] + LetterOffset;
    info_o.is_dot    = (ch_i == ChDot);
    info_o.is_hash   = (ch_i == ChHash);
    info_o.is_remote = (ch_i == ChUpR) || (ch_i == ChLowR);
    info_o.is_nul    = (ch_i == ChNul);
    info_o.dlc_ok    = is_digit && (ch_i[3:0] <= DlcMax);
  end

endmodule

// File: sv/cftp_parse_core.sv
// parser state machine: identifier, separator, data bytes and remote dlc
module cftp_parse_core
  import cftp_pkg::*;
#(
  parameter int unsigned MaxDataBytes = MaxDataBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       end_of_string_i,
  input  char_info_t info_i,
  output logic       res_valid_o,
  output frame_res_t res_o
);

  typedef enum logic [2:0] {
    PhId, PhHash, PhStart, PhRdlc, PhHi, PhLo, PhDone, PhErr
  } phase_e;

  localparam logic [3:0] MaxBytes = 4'(MaxDataBytes);

  phase_e      phase_q, phase_d;
  logic [1:0]  pos_q, pos_d;
  logic [11:0] id_q, id_d;
  logic        remote_q, remote_d;
  logic [3:0]  count_q, count_d;
  logic [63:0] store_q, store_d;
  logic [3:0]  upper_q, upper_d;
  logic        sep_q, sep_d;
  logic        ends_ok;
  logic [3:0]  count_inc;

  assign count_inc = count_q + 4'd1;

  always_comb begin
    ends_ok = (phase_q == PhStart) || (phase_q == PhRdlc) ||
              (phase_q == PhHi) || (phase_q == PhDone);

    phase_d  = phase_q;
    pos_d    = pos_q;
    id_d     = id_q;
    remote_d = remote_q;
    count_d  = count_q;
    store_d  = store_q;
    upper_d  = upper_q;
    sep_d    = sep_q;

    res_o.frame_ok       = ends_ok;
    res_o.msg_id         = ends_ok ? id_q : '0;
    res_o.remote_request = ends_ok && remote_q;
    res_o.data_length    = ends_ok ? count_q : '0;
    res_o.payload        = (ends_ok && !remote_q) ? store_q : '0;
    res_valid_o          = accept_i && end_of_string_i;

    if (accept_i) begin
      if (end_of_string_i) begin
        phase_d  = PhId;
        pos_d    = '0;
        id_d     = '0;
        remote_d = 1'b0;
        count_d  = '0;
        store_d  = '0;
        upper_d  = '0;
        sep_d    = 1'b0;
      end else if (phase_q == PhDone || phase_q == PhErr) begin
        // string already complete or in error, ignore the rest
      end else if (info_i.is_nul) begin
        phase_d = ends_ok ? PhDone : PhErr;
      end else begin
        case (phase_q)
          PhId: begin
            if (!info_i.is_hex) begin
              phase_d = PhErr;
            end else begin
              id_d  = {id_q[7:0], info_i.nibble};
              pos_d = pos_q + 2'd1;
              if (pos_q == 2'd2) phase_d = PhHash;
            end
          end
          PhHash: begin
            phase_d = info_i.is_hash ? PhStart : PhErr;
          end
          PhRdlc: begin
            if (info_i.dlc_ok) count_d = info_i.nibble;
            phase_d = PhDone;
          end
          PhLo: begin
            if (!info_i.is_hex) begin
              phase_d = PhErr;
            end else begin
              for (int i = 0; i < 8; i++) begin
                if (count_q[2:0] == 3'(i)) store_d[8*i +: 8] = {upper_q, info_i.nibble};
              end
              count_d = count_inc;
              sep_d   = 1'b0;
              phase_d = (count_inc >= MaxBytes) ? PhDone : PhHi;
            end
          end
          PhStart, PhHi: begin
            if (phase_q == PhStart && info_i.is_remote) begin
              remote_d = 1'b1;
              phase_d  = PhRdlc;
            end else if (info_i.is_dot && !sep_q) begin
              sep_d   = 1'b1;
              phase_d = PhHi;
            end else if (!info_i.is_hex) begin
              phase_d = PhErr;
            end else begin
              upper_d = info_i.nibble;
              phase_d = PhLo;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhId;
      pos_q    <= '0;
      id_q     <= '0;
      remote_q <= 1'b0;
      count_q  <= '0;
      store_q  <= '0;
      upper_q  <= '0;
      sep_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      id_q     <= id_d;
      remote_q <= remote_d;
      count_q  <= count_d;
      store_q  <= store_d;
      upper_q  <= upper_d;
      sep_q    <= sep_d;
    end
  end

  // data bytes never exceed the configured maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!remote_q) |-> (count_q <= MaxBytes))
    else $error("byte count beyond maximum");

  // a remote frame never goes back to reading data bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    remote_q |-> (phase_q == PhRdlc || phase_q == PhDone || phase_q == PhErr))
    else $error("remote frame in data phase");

  // an end item always leaves the parser cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_string_i) |=> (phase_q == PhId && store_q == '0 && !remote_q))
    else $error("parser not cleared after end item");

endmodule

// File: sv/cftp_out_stage.sv
// result register with a skid entry so the input side keeps flowing
module cftp_out_stage
  import cftp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       res_valid_i,
  input  frame_res_t res_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output frame_res_t out_o
);

  logic       out_valid_q;
  frame_res_t out_q;
  logic       skid_valid_q;
  frame_res_t skid_q;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_free) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid_i) begin
      if (out_free) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) out_q <= skid_q;
    end else if (res_valid_i) begin
      if (out_free) out_q <= res_i;
      else          skid_q <= res_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output item");

  // input side is held off while the skid entry is in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !res_valid_i)
    else $error("result arrived with skid entry full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && !skid_valid_q && res_valid_i) |=> skid_valid_q)
    else $error("stalled result lost");

endmodule

// File: sv/can_frame_text_parser_unit.sv
// top level of the can frame text parser: decode, parse state and result register
//
//  channel | direction | handshake                 | fields
//  in      | input     | in_valid_i / in_stall_o   | ch_i, end_of_string_i
//  out     | output    | out_valid_o / out_stall_i | frame_ok_o, msg_id_o,
//          |           |                           | remote_request_o, data_length_o, payload_o
//
// one character item per cycle while in_stall_o is low; the parse state updates at the accepting edge
// an accepted end item's result is registered in the output stage, or in the skid entry if the output is stalled
// reset clears the parser to wait for identifier digits and empties the output
// a stalled output parks one result in a skid entry; in_stall_o rises only
// while that entry is full, so a run of characters keeps going under stall
module can_frame_text_parser_unit
  import cftp_pkg::*;
#(
  parameter int unsigned MaxDataBytes = MaxDataBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_ok_o,
  output logic [11:0] msg_id_o,
  output logic        remote_request_o,
  output logic [3:0]  data_length_o,
  output logic [63:0] payload_o
);

  char_info_t info;
  logic       accept;
  logic       res_valid;
  frame_res_t res;
  frame_res_t out_res;
  logic       full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  cftp_char_decode u_decode (
    .ch_i   (ch_i),
    .info_o (info)
  );

  cftp_parse_core #(
    .MaxDataBytes (MaxDataBytes)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .end_of_string_i (end_of_string_i),
    .info_i          (info),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  cftp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign frame_ok_o       = out_res.frame_ok;
  assign msg_id_o         = out_res.msg_id;
  assign remote_request_o = out_res.remote_request;
  assign data_length_o    = out_res.data_length;
  assign payload_o        = out_res.payload;

endmodule
